### sv/kebd_pkg.sv
// Package for the key event buffer: command and sequencer codes, entry layout,
// register map and default sizes.
// Used by the top level and its port checker; depends on nothing.
package kebd_pkg;

  // Default number of entries in the event store.
  localparam int unsigned DEPTH_DEFAULT = 16;

  // Field widths.
  localparam int unsigned CMD_W     = 3;
  localparam int unsigned CODE_W    = 8;
  localparam int unsigned ENTRY_W   = 9;
  localparam int unsigned MSG_W     = 16;
  localparam int unsigned PENDING_W = 16;

  // Configuration port.
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  // Register index (word address) of the interrupt message register.
  localparam logic REG_IRQ_MSG = 1'b0;

  // Saturation value of the pending-interrupt count.
  localparam logic [PENDING_W-1:0] PENDING_MAX = 16'hFFFF;

  // One stored event: down flag over the scancode.
  typedef struct packed {
    logic              down;
    logic [CODE_W-1:0] code;
  } entry_t;

  // Commands of an input item.
  typedef enum logic [CMD_W-1:0] {
    CMD_KEY_EVENT = 3'd0,
    CMD_CLEAR     = 3'd1,
    CMD_POP       = 3'd2,
    CMD_IS_PRESS  = 3'd3,
    CMD_POLL      = 3'd4
  } cmd_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE = 3'd0,
    ST_EXEC = 3'd1,
    ST_READ = 3'd2,
    ST_SCAN = 3'd3,
    ST_RESP = 3'd4
  } state_e;

endpackage

### sv/key_event_buffer_device.sv
// Key event buffer top level: event store, pointers, sequencer and output register.
// Depends on kebd_pkg.
//
// Key event buffer. Items carry a command (key event, clear, pop, is-press
// query, interrupt poll) and give exactly one result item each. The block
// takes one item at a time: in_ready_o is high only while the sequencer is
// idle, and a finished result waits in an output register so the next item
// can be taken meanwhile. Key event, clear and poll go from EXEC to RESP
// and then to the output register; a pop of a nonempty store adds a READ
// state because the store is a memory with a registered read port. The
// is-press query walks the store from the newest entry toward the oldest,
// one entry per cycle through the single read port and one scancode
// compare, ending early at the first match. The interrupt message register
// sits on an APB-style port with pready tied high.
module key_event_buffer_device #(
  parameter int unsigned DEPTH = kebd_pkg::DEPTH_DEFAULT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Input item channel.
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [kebd_pkg::CMD_W-1:0]     cmd_i,
  input  logic                           key_down_i,
  input  logic [kebd_pkg::CODE_W-1:0]    scancode_i,
  // Result item channel.
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [kebd_pkg::ENTRY_W-1:0]   read_data_o,
  output logic                           irq_fire_o,
  output logic [kebd_pkg::MSG_W-1:0]     irq_message_o,
  // Configuration port.
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [kebd_pkg::PADDR_W-1:0]   paddr,
  input  logic [kebd_pkg::PDATA_W-1:0]   pwdata,
  output logic [kebd_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL     = CW'(DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

  // Pointer step forward with wrap.
  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == LAST_IDX) ? '0 : p + 1'b1;
  endfunction

  // Pointer step backward with wrap.
  function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
    return (p == '0) ? LAST_IDX : p - 1'b1;
  endfunction

  // Pointer plus an offset below DEPTH, with one compare and subtract.
  function automatic logic [AW-1:0] ptr_add(input logic [AW-1:0] p, input logic [AW-1:0] off);
    logic [AW:0] sum;
    sum = {1'b0, p} + {1'b0, off};
    if (sum >= (AW+1)'(DEPTH)) begin
      sum = sum - (AW+1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  kebd_pkg::state_e state_q, state_d;

  // Latched input item.
  logic [kebd_pkg::CMD_W-1:0]  cmd_q, cmd_d;
  logic                        down_q, down_d;
  logic [kebd_pkg::CODE_W-1:0] code_q, code_d;

  // Queue state.
  logic [AW-1:0]                  oldest_q, oldest_d;
  logic [CW-1:0]                  fill_q, fill_d;
  logic [kebd_pkg::PENDING_W-1:0] pending_q, pending_d;
  logic [kebd_pkg::MSG_W-1:0]     irq_msg_q;

  // Scan walker.
  logic [AW-1:0] scan_ptr_q, scan_ptr_d;
  logic [CW-1:0] scan_rem_q, scan_rem_d;
  logic          scan_last_q, scan_last_d;

  // Pending result.
  logic [kebd_pkg::ENTRY_W-1:0] res_data_q, res_data_d;
  logic                         res_fire_q, res_fire_d;
  logic [kebd_pkg::MSG_W-1:0]   res_msg_q, res_msg_d;

  // Output register.
  logic                         out_valid_q, out_valid_d;
  logic [kebd_pkg::ENTRY_W-1:0] out_data_q;
  logic                         out_fire_q;
  logic [kebd_pkg::MSG_W-1:0]   out_msg_q;
  logic                         out_load;

  // Event store ports.
  kebd_pkg::entry_t event_store [DEPTH];
  kebd_pkg::entry_t rd_q;
  kebd_pkg::entry_t wr_data;
  logic             we;
  logic [AW-1:0]    waddr;
  logic             re;
  logic [AW-1:0]    raddr;

  logic in_accept;
  logic cfg_write;

  assign in_ready_o = (state_q == kebd_pkg::ST_IDLE);
  assign in_accept  = in_valid_i && in_ready_o;

  // Configuration register write and read-back.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == kebd_pkg::REG_IRQ_MSG);
  assign prdata    = (paddr[2] == kebd_pkg::REG_IRQ_MSG)
                   ? {{(kebd_pkg::PDATA_W - kebd_pkg::MSG_W){1'b0}}, irq_msg_q}
                   : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      irq_msg_q <= '0;
    end else if (cfg_write) begin
      irq_msg_q <= pwdata[kebd_pkg::MSG_W-1:0];
    end
  end

  // Event store: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (we) begin
      event_store[waddr] <= wr_data;
    end
    if (re) begin
      rd_q <= event_store[raddr];
    end
  end

  // Sequencer state and working registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= kebd_pkg::ST_IDLE;
      oldest_q    <= '0;
      fill_q      <= '0;
      pending_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      oldest_q    <= oldest_d;
      fill_q      <= fill_d;
      pending_q   <= pending_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    down_q      <= down_d;
    code_q      <= code_d;
    scan_ptr_q  <= scan_ptr_d;
    scan_rem_q  <= scan_rem_d;
    scan_last_q <= scan_last_d;
    res_data_q  <= res_data_d;
    res_fire_q  <= res_fire_d;
    res_msg_q   <= res_msg_d;
    if (out_load) begin
      out_data_q <= res_data_q;
      out_fire_q <= res_fire_q;
      out_msg_q  <= res_msg_q;
    end
  end

  // Next state and datapath control.
  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    down_d      = down_q;
    code_d      = code_q;
    oldest_d    = oldest_q;
    fill_d      = fill_q;
    pending_d   = pending_q;
    scan_ptr_d  = scan_ptr_q;
    scan_rem_d  = scan_rem_q;
    scan_last_d = scan_last_q;
    res_data_d  = res_data_q;
    res_fire_d  = res_fire_q;
    res_msg_d   = res_msg_q;
    we          = 1'b0;
    waddr       = oldest_q;
    wr_data     = '{down: down_q, code: code_q};
    re          = 1'b0;
    raddr       = oldest_q;
    out_load    = 1'b0;

    unique case (state_q)
      kebd_pkg::ST_IDLE: begin
        if (in_accept) begin
          cmd_d   = cmd_i;
          down_d  = key_down_i;
          code_d  = scancode_i;
          state_d = kebd_pkg::ST_EXEC;
        end
      end

      kebd_pkg::ST_EXEC: begin
        res_data_d = '0;
        res_fire_d = 1'b0;
        res_msg_d  = '0;
        state_d    = kebd_pkg::ST_RESP;
        case (cmd_q)
          kebd_pkg::CMD_KEY_EVENT: begin
            // A full store overwrites the oldest slot and moves past it.
            we = 1'b1;
            if (fill_q == FULL) begin
              waddr    = oldest_q;
              oldest_d = ptr_inc(oldest_q);
            end else begin
              waddr  = ptr_add(oldest_q, fill_q[AW-1:0]);
              fill_d = fill_q + 1'b1;
            end
            if (pending_q != kebd_pkg::PENDING_MAX) begin
              pending_d = pending_q + 1'b1;
            end
          end
          kebd_pkg::CMD_CLEAR: begin
            fill_d   = '0;
            oldest_d = '0;
          end
          kebd_pkg::CMD_POP: begin
            if (fill_q != '0) begin
              re       = 1'b1;
              raddr    = oldest_q;
              oldest_d = ptr_inc(oldest_q);
              fill_d   = fill_q - 1'b1;
              state_d  = kebd_pkg::ST_READ;
            end
          end
          kebd_pkg::CMD_IS_PRESS: begin
            // Start at the newest entry.
            if (fill_q != '0) begin
              re          = 1'b1;
              raddr       = ptr_add(oldest_q, AW'(fill_q - 1'b1));
              scan_ptr_d  = raddr;
              scan_rem_d  = fill_q - 1'b1;
              scan_last_d = (fill_q == CW'(1));
              state_d     = kebd_pkg::ST_SCAN;
            end
          end
          kebd_pkg::CMD_POLL: begin
            if (pending_q != '0 && irq_msg_q != '0) begin
              res_fire_d = 1'b1;
              res_msg_d  = irq_msg_q;
              pending_d  = pending_q - 1'b1;
            end
          end
          default: begin
          end
        endcase
      end

      kebd_pkg::ST_READ: begin
        res_data_d = rd_q;
        state_d    = kebd_pkg::ST_RESP;
      end

      kebd_pkg::ST_SCAN: begin
        // Compare the entry read last cycle while fetching the next older one.
        if (rd_q.code == code_q) begin
          res_data_d = {{(kebd_pkg::ENTRY_W - 1){1'b0}}, rd_q.down};
          state_d    = kebd_pkg::ST_RESP;
        end else if (scan_last_q) begin
          state_d = kebd_pkg::ST_RESP;
        end else begin
          re          = 1'b1;
          raddr       = ptr_dec(scan_ptr_q);
          scan_ptr_d  = raddr;
          scan_rem_d  = scan_rem_q - 1'b1;
          scan_last_d = (scan_rem_q == CW'(1));
        end
      end

      kebd_pkg::ST_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = kebd_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = kebd_pkg::ST_IDLE;
      end
    endcase
  end

  // Output valid holds until the item is taken.
  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign read_data_o   = out_data_q;
  assign irq_fire_o    = out_fire_q;
  assign irq_message_o = out_msg_q;

endmodule

### sv/kebd_checker.sv
// Port checker for the key event buffer and the bind that attaches it.
// Depends on kebd_pkg and the top level key_event_buffer_device.
module kebd_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic [kebd_pkg::ENTRY_W-1:0] read_data_o,
  input logic                         irq_fire_o,
  input logic [kebd_pkg::MSG_W-1:0]   irq_message_o
);

  // A stalled result item keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(read_data_o) && $stable(irq_fire_o) && $stable(irq_message_o))
    else $error("result item changed while stalled");

  // A delivered interrupt always carries a nonzero message.
  a_fire_msg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && irq_fire_o |-> irq_message_o != '0)
    else $error("interrupt delivered with zero message");

  // Without an interrupt the message field is zero.
  a_no_fire_msg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !irq_fire_o |-> irq_message_o == '0)
    else $error("message shown without an interrupt");

  // An interrupt result never carries read data.
  a_fire_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && irq_fire_o |-> read_data_o == '0)
    else $error("interrupt result with read data");

endmodule

bind key_event_buffer_device kebd_checker u_kebd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .read_data_o   (read_data_o),
  .irq_fire_o    (irq_fire_o),
  .irq_message_o (irq_message_o)
);
